// ----- src/atc_pkg.sv -----
// Shared types, codes and helper functions for the ATC block decoder.
package atc_pkg;

    typedef logic [1:0] t_fmt;

    localparam t_fmt FMT_OPAQUE   = 2'd0;
    localparam t_fmt FMT_EXPLICIT = 2'd1;
    localparam t_fmt FMT_INTERP   = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    localparam int MODE_BIT = 15;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_ZERO   = 8'h00;

    // floor(n/7) == (n*RECIP7) >> RECIP7_SHIFT for every n below 2048
    localparam logic [11:0] RECIP7       = 12'd2341;
    localparam int          RECIP7_SHIFT = 14;
    // floor(n/5) == (n*RECIP5) >> RECIP5_SHIFT for every n below 2048
    localparam logic [10:0] RECIP5       = 11'd1639;
    localparam int          RECIP5_SHIFT = 13;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

// ----- src/atc_block_decoder.sv -----
// ATC 4x4 block decoder: three palette stages and a sixteen-texel emitter.
//
// Usage:
//   Present a compressed block on i_color_block / i_alpha_block and raise
//   start; the block is taken at a rising edge where start is high and busy
//   is low. Write the format register through i_cfg_we / i_cfg_wdata while
//   the block is idle; the value is sampled with each accepted block.
//   Each block yields sixteen texels in raster order, one per cycle, each
//   marked by o_strobe for exactly one cycle; o_last_texel flags texel 15.
//   A block taken while the format holds the unused code yields nothing.
// Path: an accepted block moves through stages 1, 2 and 3 into the emitter,
//   which drives the output registers; its sixteen texels leave back to back.
// Flow: the emitter walks one texel per cycle and sets the pace; the three
//   palette stages ahead of it buffer further blocks, and busy rises only
//   when all of them are full.
// Reset: synchronous, active low; clears all valid bits, the emitter and the
//   format register (opaque). The receiver cannot stall, so texels leave on
//   a fixed schedule once the emitter starts a block.
module atc_block_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [63:0]          i_color_block,
    input  logic [63:0]          i_alpha_block,
    input  logic                 i_cfg_we,
    input  atc_pkg::t_fmt        i_cfg_wdata,
    output logic                 o_strobe,
    output logic [3:0]           o_texel_index,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_alpha,
    output logic                 o_last_texel
);
    import atc_pkg::*;

    // format register
    t_fmt r_fmt;

    // stage 1: raw block
    logic        r_v1;
    logic [63:0] r_cw1;
    logic [63:0] r_aw1;
    t_fmt        r_fmt1;

    // stage 2: widened endpoints and numerators
    logic        r_v2;
    logic        r_mode2;
    t_rgb        r_e0_2;
    t_rgb        r_e1_2;
    t_rgb        r_b1_2;
    t_rgb        r_b2_2;
    t_rgb        r_dq2;
    logic [7:0]  r_a0_2;
    logic [7:0]  r_a1_2;
    logic        r_agt2;
    logic [10:0] r_n7_2 [6];
    logic [10:0] r_n5_2 [4];
    logic [31:0] r_sel2;
    logic [63:0] r_aw2;
    t_fmt        r_fmt2;

    // stage 3: final palettes
    logic        r_v3;
    t_rgb        r_pal3  [4];
    logic [7:0]  r_apal3 [8];
    logic [31:0] r_sel3;
    logic [63:0] r_aw3;
    t_fmt        r_fmt3;

    // emitter
    logic        r_em_valid;
    logic [3:0]  r_cnt;
    t_rgb        r_em_pal  [4];
    logic [7:0]  r_em_apal [8];
    logic [31:0] r_em_sel;
    logic [63:0] r_em_anib;
    logic [47:0] r_em_aind;
    t_fmt        r_em_fmt;

    // output registers
    logic        r_strobe;
    logic [3:0]  r_idx;
    t_rgb        r_rgb;
    logic [7:0]  r_alpha;
    logic        r_last;

    logic en1, en2, en3, ld, accept, fmt_ok;

    assign ld     = !r_em_valid || (r_cnt == 4'd15);
    assign en3    = !r_v3 || ld;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign busy   = !en1;
    assign accept = start && en1;
    assign fmt_ok = (r_fmt == FMT_OPAQUE) || (r_fmt == FMT_EXPLICIT)
                 || (r_fmt == FMT_INTERP);

    // ---------------- stage 1 -> 2 logic
    logic [15:0] c0, c1;
    t_rgb        n_e0, n_e1, n_b1, n_b2, n_dq;
    logic [7:0]  a0, a1;
    logic [10:0] n_n7 [6];
    logic [10:0] n_n5 [4];
    logic [9:0]  dr, dg, db;

    always_comb begin
        c0      = r_cw1[15:0];
        c1      = r_cw1[31:16];
        n_e0.r  = widen5(c0[14:10]);
        n_e0.g  = widen5(c0[9:5]);
        n_e0.b  = widen5(c0[4:0]);
        n_e1.r  = widen5(c1[15:11]);
        n_e1.g  = widen6(c1[10:5]);
        n_e1.b  = widen5(c1[4:0]);
        n_b1.r  = 8'((11'(n_e0.r) * 11'd5 + 11'(n_e1.r) * 11'd3) >> 3);
        n_b1.g  = 8'((11'(n_e0.g) * 11'd5 + 11'(n_e1.g) * 11'd3) >> 3);
        n_b1.b  = 8'((11'(n_e0.b) * 11'd5 + 11'(n_e1.b) * 11'd3) >> 3);
        n_b2.r  = 8'((11'(n_e0.r) * 11'd3 + 11'(n_e1.r) * 11'd5) >> 3);
        n_b2.g  = 8'((11'(n_e0.g) * 11'd3 + 11'(n_e1.g) * 11'd5) >> 3);
        n_b2.b  = 8'((11'(n_e0.b) * 11'd3 + 11'(n_e1.b) * 11'd5) >> 3);
        // low ten bits of the wrapped difference give the quarter
        dr      = {2'b00, n_e0.r} - {2'b00, n_e1.r};
        dg      = {2'b00, n_e0.g} - {2'b00, n_e1.g};
        db      = {2'b00, n_e0.b} - {2'b00, n_e1.b};
        n_dq.r  = dr[9:2];
        n_dq.g  = dg[9:2];
        n_dq.b  = db[9:2];
        a0      = r_aw1[7:0];
        a1      = r_aw1[15:8];
        for (int j = 0; j < 6; j++) begin
            n_n7[j] = 11'(11'(a0) * 11'(6 - j) + 11'(a1) * 11'(j + 1));
        end
        for (int j = 0; j < 4; j++) begin
            n_n5[j] = 11'(11'(a0) * 11'(4 - j) + 11'(a1) * 11'(j + 1));
        end
    end

    // ---------------- stage 2 -> 3 logic
    logic [22:0] p7 [6];
    logic [21:0] p5 [4];
    t_rgb        n_pal  [4];
    logic [7:0]  n_apal [8];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            p7[j] = 23'(r_n7_2[j]) * 23'(RECIP7);
        end
        for (int j = 0; j < 4; j++) begin
            p5[j] = 22'(r_n5_2[j]) * 22'(RECIP5);
        end
        if (r_mode2) begin
            n_pal[0] = '0;
            n_pal[1] = r_dq2;
            n_pal[2] = r_e0_2;
        end else begin
            n_pal[0] = r_e0_2;
            n_pal[1] = r_b1_2;
            n_pal[2] = r_b2_2;
        end
        n_pal[3]  = r_e1_2;
        n_apal[0] = r_a0_2;
        n_apal[1] = r_a1_2;
        for (int j = 0; j < 4; j++) begin
            n_apal[j + 2] = r_agt2 ? p7[j][RECIP7_SHIFT +: 8] : p5[j][RECIP5_SHIFT +: 8];
        end
        n_apal[6] = r_agt2 ? p7[4][RECIP7_SHIFT +: 8] : ALPHA_ZERO;
        n_apal[7] = r_agt2 ? p7[5][RECIP7_SHIFT +: 8] : ALPHA_OPAQUE;
    end

    // ---------------- emitter texel select
    logic [1:0] tsel;
    logic [3:0] nib;
    logic [2:0] aidx;
    logic [7:0] n_alpha;

    always_comb begin
        tsel = r_em_sel[1:0];
        nib  = r_em_anib[3:0];
        aidx = r_em_aind[2:0];
        case (r_em_fmt)
            FMT_OPAQUE:   n_alpha = ALPHA_OPAQUE;
            FMT_EXPLICIT: n_alpha = {nib, nib};
            default:      n_alpha = r_em_apal[aidx];
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_OPAQUE;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_em_valid <= 1'b0;
            r_cnt      <= 4'd0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_wdata;
            end
            // drop a block whose format names no scheme
            if (en1) r_v1 <= accept && fmt_ok;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (ld) begin
                r_em_valid <= r_v3;
                r_cnt      <= 4'd0;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
            r_strobe <= r_em_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cw1  <= i_color_block;
            r_aw1  <= i_alpha_block;
            r_fmt1 <= r_fmt;
        end
        if (en2) begin
            r_mode2 <= r_cw1[MODE_BIT];
            r_e0_2  <= n_e0;
            r_e1_2  <= n_e1;
            r_b1_2  <= n_b1;
            r_b2_2  <= n_b2;
            r_dq2   <= n_dq;
            r_a0_2  <= a0;
            r_a1_2  <= a1;
            r_agt2  <= a0 > a1;
            r_n7_2  <= n_n7;
            r_n5_2  <= n_n5;
            r_sel2  <= r_cw1[63:32];
            r_aw2   <= r_aw1;
            r_fmt2  <= r_fmt1;
        end
        if (en3) begin
            r_pal3  <= n_pal;
            r_apal3 <= n_apal;
            r_sel3  <= r_sel2;
            r_aw3   <= r_aw2;
            r_fmt3  <= r_fmt2;
        end
        if (ld) begin
            r_em_pal  <= r_pal3;
            r_em_apal <= r_apal3;
            r_em_sel  <= r_sel3;
            r_em_anib <= r_aw3;
            r_em_aind <= r_aw3[63:16];
            r_em_fmt  <= r_fmt3;
        end else begin
            // advance to the next texel
            r_em_sel  <= r_em_sel >> 2;
            r_em_anib <= r_em_anib >> 4;
            r_em_aind <= r_em_aind >> 3;
        end
        r_idx   <= r_cnt;
        r_rgb   <= r_em_pal[tsel];
        r_alpha <= n_alpha;
        r_last  <= r_cnt == 4'd15;
    end

    assign o_strobe      = r_strobe;
    assign o_texel_index = r_idx;
    assign o_red         = r_rgb.r;
    assign o_green       = r_rgb.g;
    assign o_blue        = r_rgb.b;
    assign o_alpha       = r_alpha;
    assign o_last_texel  = r_strobe && r_last;

endmodule

// ----- src/atc_chk.sv -----
// Port-level checks for the ATC block decoder, bound to the top level.
module atc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic [3:0] o_texel_index,
    input logic       o_last_texel
);

    // a block always opens at texel 0
    a_first_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> o_texel_index == 4'd0)
        else $error("block did not start at texel 0");

    // texels of one block leave back to back in raster order
    a_texel_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_texel |=>
            o_strobe && (o_texel_index == $past(o_texel_index) + 4'd1))
        else $error("texel run broken or out of order");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_texel |-> o_strobe && (o_texel_index == 4'd15))
        else $error("last marker away from texel 15");

    // pipeline is empty right after reset
    a_idle_after_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !busy && !o_strobe)
        else $error("busy or strobe right after reset");

endmodule

bind atc_block_decoder atc_chk u_atc_chk (.*);
